// ----- hw/rtl/cmb_pkg.sv -----
// Shared constants and calendar tables for the minutes-between calculator.
package cmb_pkg;

    localparam int YEAR_W   = 14;
    localparam int MON_W    = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int OUT_W    = 34;
    localparam int DAYS_W   = 24;
    localparam int CLK_W    = 12;
    localparam int CUM_W    = 9;
    localparam int Q_W      = 8;
    localparam int LEAPS_W  = 12;
    localparam int YSPAN_W  = 23;

    localparam logic [YEAR_W-1:0] YEAR_MAX      = YEAR_W'(9999);
    localparam int                MIN_PER_DAY   = 1440;
    localparam int                MIN_PER_HOUR  = 60;
    localparam int                DAYS_PER_YEAR = 365;

    // floor(y/100) = (y * 5243) >> 19, exact for y below 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = YEAR_W + 13;

    // Length of month m; codes outside 1..12 count as 30 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_W'(31);
            4'd2:                                       d = DAY_W'(28) + DAY_W'(leap);
            default:                                    d = DAY_W'(30);
        endcase
        return d;
    endfunction

    // Days in the real months 1..12 that come before month m.
    function automatic logic [CUM_W-1:0] days_before_month(input logic [MON_W:0] m,
                                                           input logic leap);
        logic [CUM_W-1:0] base;
        case (m) inside
            5'd0, 5'd1: base = CUM_W'(0);
            5'd2:       base = CUM_W'(31);
            5'd3:       base = CUM_W'(59);
            5'd4:       base = CUM_W'(90);
            5'd5:       base = CUM_W'(120);
            5'd6:       base = CUM_W'(151);
            5'd7:       base = CUM_W'(181);
            5'd8:       base = CUM_W'(212);
            5'd9:       base = CUM_W'(243);
            5'd10:      base = CUM_W'(273);
            5'd11:      base = CUM_W'(304);
            5'd12:      base = CUM_W'(334);
            default:    base = CUM_W'(365);
        endcase
        return base + ((m >= 5'd3) ? CUM_W'(leap) : CUM_W'(0));
    endfunction

endpackage

// ----- hw/rtl/calendar_minutes_between.sv -----
// Minutes between two Gregorian date-times, five-stage pipeline.
// A request accepted into stage A moves through stages B, C, D and E in turn before it shows on m_valid.
// Throughput: one request per cycle while m_ready does not hold the output; every stage has its own valid bit
// and stalls only when the stage after it is full and stalled as well, so bubbles are squeezed out.
// The year spans use closed-form leap counts with a reciprocal multiply for /100.
// Reset (aresetn low, synchronous) empties all stages; payload registers keep data.
module calendar_minutes_between (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cmb_pkg::YEAR_W-1:0]      s_start_year,
    input  logic [cmb_pkg::MON_W-1:0]       s_start_month,
    input  logic [cmb_pkg::DAY_W-1:0]       s_start_day,
    input  logic [cmb_pkg::HOUR_W-1:0]      s_start_hour,
    input  logic [cmb_pkg::MIN_W-1:0]       s_start_minute,
    input  logic [cmb_pkg::YEAR_W-1:0]      s_end_year,
    input  logic [cmb_pkg::MON_W-1:0]       s_end_month,
    input  logic [cmb_pkg::DAY_W-1:0]       s_end_day,
    input  logic [cmb_pkg::HOUR_W-1:0]      s_end_hour,
    input  logic [cmb_pkg::MIN_W-1:0]       s_end_minute,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [cmb_pkg::OUT_W-1:0] m_minutes_between
);

    localparam int YW = cmb_pkg::YEAR_W;
    localparam int MW = cmb_pkg::MON_W;
    localparam int DW = cmb_pkg::DAY_W;
    localparam int HW = cmb_pkg::HOUR_W;
    localparam int NW = cmb_pkg::MIN_W;
    localparam int QW = cmb_pkg::Q_W;
    localparam int PW = cmb_pkg::DIV100_PW;
    localparam int LW = cmb_pkg::LEAPS_W;
    localparam int SW = cmb_pkg::YSPAN_W;
    localparam int KW = cmb_pkg::CLK_W;
    localparam int AW = cmb_pkg::DAYS_W;
    localparam int OW = cmb_pkg::OUT_W;

    // ---------------- handshake ----------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic a_rdy, b_rdy, c_rdy, d_rdy, m_rdy;

    assign m_rdy   = !m_valid_reg || m_ready;
    assign d_rdy   = !d_valid_reg || m_rdy;
    assign c_rdy   = !c_valid_reg || d_rdy;
    assign b_rdy   = !b_valid_reg || c_rdy;
    assign a_rdy   = !a_valid_reg || b_rdy;
    assign s_ready = a_rdy;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) a_valid_reg <= s_valid;
            if (b_rdy) b_valid_reg <= a_valid_reg;
            if (c_rdy) c_valid_reg <= b_valid_reg;
            if (d_rdy) d_valid_reg <= c_valid_reg;
            if (m_rdy) m_valid_reg <= d_valid_reg;
        end
    end

    // ---------------- stage A: capture, clamp years ----------------
    logic [YW-1:0] a_sy_reg, a_ey_reg;
    logic [MW-1:0] a_smo_reg, a_emo_reg;
    logic [DW-1:0] a_sd_reg, a_ed_reg;
    logic [HW-1:0] a_sh_reg, a_eh_reg;
    logic [NW-1:0] a_smi_reg, a_emi_reg;
    logic [YW-1:0] a_sy_next, a_ey_next;

    assign a_sy_next = (s_start_year > cmb_pkg::YEAR_MAX) ? cmb_pkg::YEAR_MAX : s_start_year;
    assign a_ey_next = (s_end_year > cmb_pkg::YEAR_MAX) ? cmb_pkg::YEAR_MAX : s_end_year;

    always_ff @(posedge aclk) begin
        if (a_rdy && s_valid) begin
            a_sy_reg  <= a_sy_next;
            a_ey_reg  <= a_ey_next;
            a_smo_reg <= s_start_month;
            a_emo_reg <= s_end_month;
            a_sd_reg  <= s_start_day;
            a_ed_reg  <= s_end_day;
            a_sh_reg  <= s_start_hour;
            a_eh_reg  <= s_end_hour;
            a_smi_reg <= s_start_minute;
            a_emi_reg <= s_end_minute;
        end
    end

    // ---------------- stage B: /100 products, year*365, clock part ----------------
    logic [PW-1:0]        prod_s, prod_e, prod_a;
    logic [YW-1:0]        ey_m1, yd;
    logic signed [HW:0]   hour_diff;
    logic signed [NW:0]   min_diff;
    logic signed [KW-1:0] b_clk_next;
    logic [SW-1:0]        b_y365_next;

    assign ey_m1  = a_ey_reg - YW'(1);
    assign yd     = a_ey_reg - a_sy_reg - YW'(1);
    assign prod_s = PW'(a_sy_reg) * PW'(cmb_pkg::DIV100_MUL);
    assign prod_e = PW'(a_ey_reg) * PW'(cmb_pkg::DIV100_MUL);
    assign prod_a = PW'(ey_m1) * PW'(cmb_pkg::DIV100_MUL);
    assign b_y365_next = SW'(yd) * SW'(cmb_pkg::DAYS_PER_YEAR);

    assign hour_diff  = signed'({1'b0, a_eh_reg}) - signed'({1'b0, a_sh_reg});
    assign min_diff   = signed'({1'b0, a_emi_reg}) - signed'({1'b0, a_smi_reg});
    assign b_clk_next = KW'(KW'(hour_diff) * KW'(cmb_pkg::MIN_PER_HOUR)) + KW'(min_diff);

    logic [YW-1:0]        b_sy_reg, b_ey_reg, b_eym1_reg;
    logic [QW-1:0]        b_qs_reg, b_qe_reg, b_qa_reg;
    logic [SW-1:0]        b_y365_reg;
    logic                 b_span_ok_reg, b_same_y_reg, b_same_ym_reg;
    logic [MW-1:0]        b_smo_reg, b_emo_reg;
    logic [DW-1:0]        b_sd_reg, b_ed_reg;
    logic signed [KW-1:0] b_clk_reg;

    always_ff @(posedge aclk) begin
        if (b_rdy && a_valid_reg) begin
            b_sy_reg      <= a_sy_reg;
            b_ey_reg      <= a_ey_reg;
            b_eym1_reg    <= ey_m1;
            b_qs_reg      <= prod_s[cmb_pkg::DIV100_SHIFT +: QW];
            b_qe_reg      <= prod_e[cmb_pkg::DIV100_SHIFT +: QW];
            b_qa_reg      <= prod_a[cmb_pkg::DIV100_SHIFT +: QW];
            b_y365_reg    <= b_y365_next;
            b_span_ok_reg <= ({1'b0, a_ey_reg} >= ({1'b0, a_sy_reg} + (YW+1)'(2)));
            b_same_y_reg  <= (a_sy_reg == a_ey_reg);
            b_same_ym_reg <= (a_sy_reg == a_ey_reg) && (a_smo_reg == a_emo_reg);
            b_smo_reg     <= a_smo_reg;
            b_emo_reg     <= a_emo_reg;
            b_sd_reg      <= a_sd_reg;
            b_ed_reg      <= a_ed_reg;
            b_clk_reg     <= b_clk_next;
        end
    end

    // ---------------- stage C: leap flags, whole-year span ----------------
    logic          cent_s, cent_e, c_leap_s_next, c_leap_e_next;
    logic [LW-1:0] leaps_a, leaps_s;
    logic [SW-1:0] yspan_raw, c_yspan_next;

    assign cent_s = ({1'b0, b_sy_reg} == (YW+1)'((YW+1)'(b_qs_reg) * (YW+1)'(100)));
    assign cent_e = ({1'b0, b_ey_reg} == (YW+1)'((YW+1)'(b_qe_reg) * (YW+1)'(100)));
    assign c_leap_s_next = cent_s ? (b_qs_reg[1:0] == 2'b00) : (b_sy_reg[1:0] == 2'b00);
    assign c_leap_e_next = cent_e ? (b_qe_reg[1:0] == 2'b00) : (b_ey_reg[1:0] == 2'b00);

    // leaps in 1..y = y/4 - y/100 + y/400
    assign leaps_a = LW'(b_eym1_reg >> 2) - LW'(b_qa_reg) + LW'(b_qa_reg >> 2);
    assign leaps_s = LW'(b_sy_reg >> 2) - LW'(b_qs_reg) + LW'(b_qs_reg >> 2);
    assign yspan_raw    = b_y365_reg + SW'(leaps_a) - SW'(leaps_s);
    assign c_yspan_next = b_span_ok_reg ? yspan_raw : '0;

    logic                 c_leap_s_reg, c_leap_e_reg;
    logic [SW-1:0]        c_yspan_reg;
    logic                 c_same_y_reg, c_same_ym_reg;
    logic [MW-1:0]        c_smo_reg, c_emo_reg;
    logic [DW-1:0]        c_sd_reg, c_ed_reg;
    logic signed [KW-1:0] c_clk_reg;
    logic                 c_span_ok_reg;

    always_ff @(posedge aclk) begin
        if (c_rdy && b_valid_reg) begin
            c_leap_s_reg  <= c_leap_s_next;
            c_leap_e_reg  <= c_leap_e_next;
            c_yspan_reg   <= c_yspan_next;
            c_span_ok_reg <= b_span_ok_reg;
            c_same_y_reg  <= b_same_y_reg;
            c_same_ym_reg <= b_same_ym_reg;
            c_smo_reg     <= b_smo_reg;
            c_emo_reg     <= b_emo_reg;
            c_sd_reg      <= b_sd_reg;
            c_ed_reg      <= b_ed_reg;
            c_clk_reg     <= b_clk_reg;
        end
    end

    // ---------------- stage D: day count ----------------
    logic [DW-1:0]            mds;
    logic [cmb_pkg::CUM_W-1:0] gs1, ges, gee;
    logic [AW-1:0]            span_same, span_other, d_days_next;

    assign mds = cmb_pkg::month_days(c_smo_reg, c_leap_s_reg);
    assign gs1 = cmb_pkg::days_before_month({1'b0, c_smo_reg} + (MW+1)'(1), c_leap_s_reg);
    assign ges = cmb_pkg::days_before_month({1'b0, c_emo_reg}, c_leap_s_reg);
    assign gee = cmb_pkg::days_before_month({1'b0, c_emo_reg}, c_leap_e_reg);

    // backward month span within one year counts as empty
    assign span_same  = (ges > gs1) ? AW'(ges - gs1) : '0;
    assign span_other = AW'(cmb_pkg::DAYS_PER_YEAR) + AW'(c_leap_s_reg) - AW'(gs1)
                        + AW'(gee) + AW'(c_yspan_reg);

    always_comb begin
        if (c_same_ym_reg) begin
            d_days_next = AW'(c_ed_reg) - AW'(c_sd_reg);
        end else begin
            d_days_next = AW'(mds) - AW'(c_sd_reg) + AW'(c_ed_reg) - AW'(1)
                          + (c_same_y_reg ? span_same : span_other);
        end
    end

    logic signed [AW-1:0] d_days_reg;
    logic signed [KW-1:0] d_clk_reg;
    logic                 d_same_ym_reg;

    always_ff @(posedge aclk) begin
        if (d_rdy && c_valid_reg) begin
            d_days_reg    <= d_days_next;
            d_clk_reg     <= c_clk_reg;
            d_same_ym_reg <= c_same_ym_reg;
        end
    end

    // ---------------- stage E: minutes ----------------
    logic signed [OW-1:0] days_x, m_min_next;
    logic signed [OW-1:0] m_min_reg;

    assign days_x     = OW'(d_days_reg);
    assign m_min_next = OW'(days_x * OW'(cmb_pkg::MIN_PER_DAY)) + OW'(d_clk_reg);

    always_ff @(posedge aclk) begin
        if (m_rdy && d_valid_reg) begin
            m_min_reg <= m_min_next;
        end
    end

    assign m_minutes_between = m_min_reg;

    // ---------------- assertions ----------------
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> a_valid_reg)
        else $error("accepted request did not enter stage A");

    a_same_month_days: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg && d_same_ym_reg |-> (d_days_reg >= -AW'(31)) && (d_days_reg <= AW'(31)))
        else $error("same-month day difference out of range");

    a_year_span_min: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_span_ok_reg |-> c_yspan_reg >= SW'(cmb_pkg::DAYS_PER_YEAR))
        else $error("whole-year span shorter than one year");

    a_out_from_d: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(d_valid_reg))
        else $error("result appeared without a request in stage D");

endmodule
